>>> sv/mtwa_pkg.sv
`default_nettype none

package mtwa_pkg;

	// Field and storage widths
	localparam int SAMPLE_W  = 16;
	localparam int NUM_CH    = 12;
	localparam int NUM_ACC   = 6;
	localparam int CNT_W     = 10;
	localparam int SUM_W     = SAMPLE_W + CNT_W;
	localparam int THR_W     = 16;
	localparam int CH_W      = 4;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	// Window queue between front and back (depth is a power of two)
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	// Divider: one quotient bit per cycle
	localparam int DIV_STEPS = SAMPLE_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	// Register reset values
	localparam logic [THR_W-1:0] RESET_THRESHOLD = 16'd8192;
	localparam logic [CNT_W-1:0] RESET_WINDOW    = 10'd150;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELTA_THRESHOLD = 1'b0,
		REG_WINDOW_LENGTH   = 1'b1
	} cfg_reg_t;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic [CNT_W-1:0]           cnt_t;

	// One finished window: the twelve sums and the sample count
	typedef struct packed {
		sum_t [NUM_CH-1:0] sums;
		cnt_t              count;
	} job_t;

	// Queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_LOAD,
		B_DIV,
		B_OUT
	} back_state_t;

	// Accelerometer lane i -> input channel (0-2 and 6-8)
	function automatic logic [CH_W-1:0] accel_channel(input int i);
		return (i < 3) ? CH_W'(i) : CH_W'(i + 3);
	endfunction

endpackage

`default_nettype wire

>>> sv/motion_triggered_window_averager_top.sv
// Channel  | Direction | Handshake                   | Payload
// sample   | in        | sample_valid / sample_stall | acc1_x .. rate2_z, 16 bit signed each
// result   | out       | result_valid / result_stall | channel[3:0], average[15:0], last
// config   | in        | cfg_wr_en, no wait          | cfg_index[0], cfg_data[15:0]
//
// A sample is taken every cycle while the window queue has room; each sample is held in
// the sample register before it is summed.
// For each finished window the shared divider takes the 12 channels in turn: a load,
// one step per bit of the 16-bit quotient and a result-register write; then it returns to idle.
// The queue holds two finished windows; sample_stall rises only when a window-ending
// sample finds it full. result_stall holds the result register and a finished divider.
// Reset is immediate with no clearing pass; registers return to 8192 and 150.
`default_nettype none

module motion_triggered_window_averager_top import mtwa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  sample_t              acc1_x,
	input  sample_t              acc1_y,
	input  sample_t              acc1_z,
	input  sample_t              rate1_x,
	input  sample_t              rate1_y,
	input  sample_t              rate1_z,
	input  sample_t              acc2_x,
	input  sample_t              acc2_y,
	input  sample_t              acc2_z,
	input  sample_t              rate2_x,
	input  sample_t              rate2_y,
	input  sample_t              rate2_z,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [CH_W-1:0]      channel,
	output sample_t              average,
	output logic                 last,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [THR_W-1:0] threshold_q;
	cnt_t             window_q;
	sample_t          samples [NUM_CH];
	logic             push;
	logic             pop;
	job_t             wr_job;
	job_t             rd_job;
	qstat_t           qstat;

	// Channel order of the sample request
	assign samples[0]  = acc1_x;
	assign samples[1]  = acc1_y;
	assign samples[2]  = acc1_z;
	assign samples[3]  = rate1_x;
	assign samples[4]  = rate1_y;
	assign samples[5]  = rate1_z;
	assign samples[6]  = acc2_x;
	assign samples[7]  = acc2_y;
	assign samples[8]  = acc2_z;
	assign samples[9]  = rate2_x;
	assign samples[10] = rate2_y;
	assign samples[11] = rate2_z;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= RESET_THRESHOLD;
			window_q    <= RESET_WINDOW;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DELTA_THRESHOLD: threshold_q <= cfg_data[THR_W-1:0];
				REG_WINDOW_LENGTH:   window_q    <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	mtwa_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.samples      (samples),
		.threshold    (threshold_q),
		.window       (window_q),
		.qstat        (qstat),
		.push         (push),
		.job          (wr_job)
	);

	mtwa_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (rd_job),
		.qstat  (qstat)
	);

	mtwa_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job          (rd_job),
		.qstat        (qstat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.channel      (channel),
		.average      (average),
		.last         (last)
	);

endmodule

`default_nettype wire

>>> sv/mtwa_front.sv
`default_nettype none

module mtwa_front import mtwa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  sample_t            samples [NUM_CH],
	input  logic [THR_W-1:0]   threshold,
	input  cnt_t               window,
	input  qstat_t             qstat,
	output logic               push,
	output job_t               job
);

	sample_t prev_q [NUM_ACC];
	sample_t smp_s1 [NUM_CH];
	logic    trig_s1;
	logic    valid_s1;
	logic    capturing_q;
	cnt_t    cnt_q;
	sum_t    sums_q [NUM_CH];

	logic             accept;
	logic             trig;
	logic             cap_now;
	logic             ends;
	logic             fire;
	cnt_t             cnt_base;
	logic [CNT_W:0]   cnt_inc;
	cnt_t             cnt_next;
	sum_t             sums_next [NUM_CH];

	// Trigger: any accel lane moved by more than the threshold
	always_comb begin
		logic signed [SAMPLE_W:0] diff;
		logic [SAMPLE_W:0]        mag;
		sample_t                  cur;
		trig = 1'b0;
		for (int i = 0; i < NUM_ACC; i++) begin
			cur  = samples[accel_channel(i)];
			diff = $signed({cur[SAMPLE_W-1], cur})
				- $signed({prev_q[i][SAMPLE_W-1], prev_q[i]});
			mag  = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : diff;
			if (mag > {1'b0, threshold}) begin
				trig = 1'b1;
			end
		end
	end

	// Accumulate stage: count saturates at its top value
	always_comb begin
		cap_now  = capturing_q | trig_s1;
		cnt_base = capturing_q ? cnt_q : '0;
		cnt_inc  = {1'b0, cnt_base} + (CNT_W+1)'(1);
		cnt_next = cnt_inc[CNT_W] ? '1 : cnt_inc[CNT_W-1:0];
		ends     = cap_now && (cnt_next >= window);
		fire     = valid_s1 && !(ends && qstat.full);
		for (int i = 0; i < NUM_CH; i++) begin
			sums_next[i] = (capturing_q ? sums_q[i] : '0)
				+ {{(SUM_W-SAMPLE_W){smp_s1[i][SAMPLE_W-1]}}, smp_s1[i]};
			job.sums[i]  = sums_next[i];
		end
		job.count = cnt_next;
	end

	assign push         = fire && ends;
	assign sample_stall = valid_s1 && !fire;
	assign accept       = sample_valid && !sample_stall;

	// Previous accel values follow every accepted sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ACC; i++) begin
				prev_q[i] <= '0;
			end
		end else if (accept) begin
			for (int i = 0; i < NUM_ACC; i++) begin
				prev_q[i] <= samples[accel_channel(i)];
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			capturing_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire && cap_now) begin
				capturing_q <= !ends;
				cnt_q       <= cnt_next;
			end
		end
	end

	// Sample register and running sums
	always_ff @(posedge clk) begin
		if (accept) begin
			smp_s1  <= samples;
			trig_s1 <= trig;
		end
		if (fire && cap_now) begin
			sums_q <= sums_next;
		end
	end

endmodule

`default_nettype wire

>>> sv/mtwa_queue.sv
`default_nettype none

module mtwa_queue import mtwa_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  job_t   wr_job,
	input  logic   pop,
	output job_t   rd_job,
	output qstat_t qstat
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	assign qstat.full  = (fill_q == (QPTR_W+1)'(QDEPTH));
	assign qstat.empty = (fill_q == '0);
	assign rd_job      = mem_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + (QPTR_W+1)'(1);
				2'b01:   fill_q <= fill_q - (QPTR_W+1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

`default_nettype wire

>>> sv/mtwa_back.sv
`default_nettype none

module mtwa_back import mtwa_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  job_t            job,
	input  qstat_t          qstat,
	output logic            pop,
	output logic            result_valid,
	input  logic            result_stall,
	output logic [CH_W-1:0] channel,
	output sample_t         average,
	output logic            last
);

	back_state_t         state_q;
	back_state_t         state_nxt;
	logic [CH_W-1:0]     ch_q;
	logic [STEP_W-1:0]   step_q;
	logic [CNT_W-1:0]    rem_q;
	logic [SAMPLE_W-1:0] quo_q;
	logic                neg_q;
	logic                valid_q;
	logic [CH_W-1:0]     channel_q;
	sample_t             avg_q;
	logic                last_q;

	sum_t             sum_sel;
	logic [SUM_W-1:0] mag;
	logic [CNT_W:0]   trial;
	logic             ge;
	logic [CNT_W-1:0] rem_next;
	logic             out_free;
	logic             last_ch;
	logic             steps_done;
	logic             load;
	logic             step_en;
	logic             wr;

	// Operand select and one restoring-division step
	always_comb begin
		sum_sel    = job.sums[ch_q];
		mag        = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : sum_sel;
		trial      = {rem_q, quo_q[SAMPLE_W-1]};
		ge         = (trial >= {1'b0, job.count});
		rem_next   = ge ? CNT_W'(trial - {1'b0, job.count}) : trial[CNT_W-1:0];
		out_free   = !valid_q || !result_stall;
		last_ch    = (ch_q == CH_W'(NUM_CH - 1));
		steps_done = (step_q == STEP_W'(DIV_STEPS - 1));
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!qstat.empty) begin
					state_nxt = B_LOAD;
				end
			end
			B_LOAD: begin
				state_nxt = B_DIV;
			end
			B_DIV: begin
				if (steps_done) begin
					state_nxt = B_OUT;
				end
			end
			B_OUT: begin
				if (out_free) begin
					state_nxt = last_ch ? B_IDLE : B_LOAD;
				end
			end
		endcase
	end

	// State outputs
	always_comb begin
		load    = 1'b0;
		step_en = 1'b0;
		wr      = 1'b0;
		unique case (state_q)
			B_IDLE: begin
			end
			B_LOAD: begin
				load = 1'b1;
			end
			B_DIV: begin
				step_en = 1'b1;
			end
			B_OUT: begin
				wr = out_free;
			end
		endcase
	end

	assign pop = wr && last_ch;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			ch_q    <= '0;
			step_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (wr) begin
				ch_q <= last_ch ? '0 : ch_q + CH_W'(1);
			end
			if (load) begin
				step_q <= '0;
			end else if (step_en) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (wr) begin
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Divider datapath and result register
	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= mag[SUM_W-1:SAMPLE_W];
			quo_q <= mag[SAMPLE_W-1:0];
			neg_q <= sum_sel[SUM_W-1];
		end else if (step_en) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[SAMPLE_W-2:0], ge};
		end
		if (wr) begin
			channel_q <= ch_q;
			avg_q     <= neg_q ? -quo_q : quo_q;
			last_q    <= last_ch;
		end
	end

	assign result_valid = valid_q;
	assign channel      = channel_q;
	assign average      = avg_q;
	assign last         = last_q;

endmodule

`default_nettype wire

>>> sv/mtwa_checker.sv
`default_nettype none

module mtwa_checker import mtwa_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            sample_stall,
	input logic            result_valid,
	input logic            result_stall,
	input logic [CH_W-1:0] channel,
	input sample_t         average,
	input logic            last
);

	// last marks exactly the final channel of a burst
	a_last_channel: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (last == (channel == CH_W'(NUM_CH - 1))))
		else $error("last flag does not match final channel");

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(channel) && $stable(average) && $stable(last))
		else $error("stalled result changed");

	// the divider must produce the next result before result_valid rises again
	a_result_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall |=> !result_valid)
		else $error("results closer than one division");

	// out of reset nothing is pending on either side
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !result_valid && !sample_stall)
		else $error("activity right after reset");

endmodule

bind motion_triggered_window_averager_top mtwa_checker u_mtwa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_stall (sample_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.channel      (channel),
	.average      (average),
	.last         (last)
);

`default_nettype wire

>>> sim/tb_motion_triggered_window_averager_top.sv
`timescale 1ns / 1ps

module tb_motion_triggered_window_averager_top;
	import mtwa_pkg::*;

	localparam int RANDOM_ITEMS      = 230;
	localparam int LONG_WINDOW_ITEMS = 200;
	localparam int SETTLE_CYCLES     = 16;
	localparam int TAIL_CYCLES       = 300;
	localparam int MAX_REPORTS       = 20;

	// Power-on register values
	localparam logic [THR_W-1:0] THRESH_AT_RESET = 16'd8192;
	localparam cnt_t             LENGTH_AT_RESET = 10'd150;

	typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] frame_t;

	typedef struct {
		logic [CH_W-1:0] ch;
		sample_t         avg;
		logic            lst;
	} avg_result_t;

	logic                 clk;
	logic                 arst_n        = 1'b0;
	logic                 sample_valid  = 1'b0;
	logic                 sample_stall;
	frame_t               stim_frame    = '0;
	logic                 result_valid;
	logic                 result_stall  = 1'b0;
	logic [CH_W-1:0]      channel;
	sample_t              average;
	logic                 last;
	logic                 cfg_wr_en     = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index     = REG_DELTA_THRESHOLD;
	logic [CFG_W-1:0]     cfg_data      = '0;

	// Shadow of the block: registers, accel history and open window
	logic [THR_W-1:0] thresh_shadow = THRESH_AT_RESET;
	cnt_t             length_shadow = LENGTH_AT_RESET;
	sample_t          acc_history [NUM_ACC] = '{default: '0};
	logic             in_window     = 1'b0;
	cnt_t             window_count  = '0;
	longint           running_sum [NUM_CH] = '{default: 0};

	avg_result_t pending_averages[$];

	bit sender_idles   = 1'b1;
	bit receiver_idles = 1'b1;
	int rx_hold        = 0;
	int fail_count     = 0;
	int frames_sent    = 0;
	int windows_closed = 0;
	int averages_seen  = 0;
	int cfg_writes     = 0;

	motion_triggered_window_averager_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.acc1_x       (stim_frame[0]),
		.acc1_y       (stim_frame[1]),
		.acc1_z       (stim_frame[2]),
		.rate1_x      (stim_frame[3]),
		.rate1_y      (stim_frame[4]),
		.rate1_z      (stim_frame[5]),
		.acc2_x       (stim_frame[6]),
		.acc2_y       (stim_frame[7]),
		.acc2_z       (stim_frame[8]),
		.rate2_x      (stim_frame[9]),
		.rate2_y      (stim_frame[10]),
		.rate2_z      (stim_frame[11]),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.channel      (channel),
		.average      (average),
		.last         (last),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Accel lane -> channel: lanes 0-2 are channels 0-2, lanes 3-5 are 6-8
	function automatic int accel_lane(input int k);
		return (k < 3) ? k : k + 3;
	endfunction

	function automatic sample_t clamp16(input int v);
		if (v > 32767) return 16'sh7FFF;
		if (v < -32768) return 16'sh8000;
		return sample_t'(v);
	endfunction

	// Advance the shadow by one accepted sample, queue any burst of averages
	function automatic void predict_averages(input frame_t f);
		logic        moved;
		int          d;
		longint      q;
		avg_result_t r;
		moved = 1'b0;
		for (int k = 0; k < NUM_ACC; k++) begin
			d = int'(sample_t'(f[accel_lane(k)])) - int'(acc_history[k]);
			if (d < 0) d = -d;
			if (d > int'(thresh_shadow)) moved = 1'b1;
		end
		if (moved && !in_window) begin
			in_window    = 1'b1;
			window_count = '0;
			for (int i = 0; i < NUM_CH; i++) running_sum[i] = 0;
		end
		if (in_window) begin
			for (int i = 0; i < NUM_CH; i++) running_sum[i] += sample_t'(f[i]);
			// count saturates instead of wrapping to zero
			window_count = window_count + 1'b1;
			if (window_count == '0) window_count = '1;
			if (window_count >= length_shadow) begin
				for (int i = 0; i < NUM_CH; i++) begin
					q     = running_sum[i] / longint'(window_count);
					r.ch  = CH_W'(i);
					r.avg = sample_t'(q);
					r.lst = (i == NUM_CH - 1);
					pending_averages.push_back(r);
				end
				in_window = 1'b0;
				windows_closed++;
			end
		end
		for (int k = 0; k < NUM_ACC; k++) acc_history[k] = sample_t'(f[accel_lane(k)]);
	endfunction

	// Frame builders
	function automatic frame_t flat_frame(input int v);
		frame_t f;
		for (int i = 0; i < NUM_CH; i++) f[i] = clamp16(v);
		return f;
	endfunction

	function automatic frame_t held_frame();
		frame_t f;
		f = '0;
		for (int k = 0; k < NUM_ACC; k++) f[accel_lane(k)] = acc_history[k];
		return f;
	endfunction

	// Accel moves no more than the threshold; gyros anywhere
	function automatic frame_t quiet_frame();
		frame_t f;
		int     j;
		for (int i = 0; i < NUM_CH; i++) f[i] = SAMPLE_W'($urandom);
		for (int k = 0; k < NUM_ACC; k++) begin
			j = (thresh_shadow == 0) ? 0 : int'($urandom_range(0, int'(thresh_shadow)));
			if ($urandom_range(0, 1)) j = -j;
			f[accel_lane(k)] = clamp16(int'(acc_history[k]) + j);
		end
		return f;
	endfunction

	// One accel lane jumps past the threshold where the range allows it
	function automatic frame_t jump_frame();
		frame_t f;
		int     k, p, far_end, room, step, v;
		f       = quiet_frame();
		k       = $urandom_range(0, NUM_ACC - 1);
		p       = int'(acc_history[k]);
		far_end = (p >= 0) ? -32768 : 32767;
		room    = (far_end > p) ? far_end - p : p - far_end;
		if (room > int'(thresh_shadow)) begin
			step = $urandom_range(int'(thresh_shadow) + 1, room);
			v    = (far_end > p) ? p + step : p - step;
		end else begin
			v = far_end;
		end
		f[accel_lane(k)] = clamp16(v);
		return f;
	endfunction

	// Content inside an open window
	function automatic frame_t window_frame();
		frame_t f;
		case ($urandom_range(0, 3))
			0: begin
				for (int i = 0; i < NUM_CH; i++) f[i] = SAMPLE_W'($urandom);
			end
			1: begin
				for (int i = 0; i < NUM_CH; i++)
					f[i] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			end
			2: begin
				for (int i = 0; i < NUM_CH; i++)
					f[i] = clamp16(int'($urandom_range(0, 16)) - 8);
			end
			default: f = quiet_frame();
		endcase
		return f;
	endfunction

	// One sample request; valid stays high on return
	task automatic send_frame(input frame_t f);
		int gap;
		gap = sender_idles ? $urandom_range(0, 4) : 0;
		if (gap != 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		stim_frame   <= f;
		do @(posedge clk); while (sample_stall);
		predict_averages(f);
		frames_sent++;
	endtask

	// Stop sending, wait for all averages, then let the sample pipe settle
	task automatic drain_averages();
		sample_valid <= 1'b0;
		while (pending_averages.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write enable drops one cycle, so back-to-back writes stay separate
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_DELTA_THRESHOLD: thresh_shadow = data[THR_W-1:0];
			REG_WINDOW_LENGTH:   length_shadow = data[CNT_W-1:0];
			default: ;
		endcase
		cfg_writes++;
	endtask

	// Result side: compare against the oldest expected average
	task automatic check_average();
		avg_result_t want;
		averages_seen++;
		if (pending_averages.size() == 0) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t: unexpected average: ch=%0d avg=%0d last=%0b",
					$time, channel, average, last);
		end else begin
			want = pending_averages.pop_front();
			if (want.ch !== channel || want.avg !== average || want.lst !== last) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t: mismatch: expected ch=%0d avg=%0d last=%0b, got ch=%0d avg=%0d last=%0b",
						$time, want.ch, want.avg, want.lst, channel, average, last);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				check_average();
				rx_hold = receiver_idles ? $urandom_range(0, 4) : 0;
			end
			if (rx_hold > 0) begin
				result_stall <= 1'b1;
				rx_hold--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Power-on registers: threshold boundary at 8192, then window shortened mid-capture
	task automatic test_reset_registers();
		frame_t f;
		send_frame(flat_frame(0));
		f    = flat_frame(0);
		f[0] = 16'sd8192;
		send_frame(f);
		f    = flat_frame(-7);
		f[0] = -16'sd1;
		send_frame(f);
		send_frame(flat_frame(3));
		send_frame(flat_frame(2));
		drain_averages();
		// count is already past the new length, so the next sample closes it
		write_reg(REG_WINDOW_LENGTH, 16'd2);
		send_frame(flat_frame(-5));
		drain_averages();
	endtask

	// Each accel lane can trigger alone; gyro swings and a change equal to the threshold cannot
	task automatic test_each_lane_triggers();
		frame_t f;
		write_reg(REG_DELTA_THRESHOLD, 16'd100);
		write_reg(REG_WINDOW_LENGTH, 16'hFC01);
		f = held_frame();
		for (int i = 0; i < NUM_CH; i++)
			if (i % 6 >= 3) f[i] = (i % 2) ? 16'h7FFF : 16'h8000;
		send_frame(f);
		f    = held_frame();
		f[0] = clamp16(int'(acc_history[0]) + 100);
		send_frame(f);
		for (int k = 0; k < NUM_ACC; k++) begin
			f = held_frame();
			f[accel_lane(k)] = clamp16(int'(acc_history[k]) + 101);
			f[3]  = SAMPLE_W'($urandom);
			f[11] = SAMPLE_W'($urandom);
			send_frame(f);
		end
		drain_averages();
	endtask

	// Threshold at full scale never fires; at zero any change fires; zero length
	task automatic test_threshold_extremes();
		frame_t f;
		write_reg(REG_DELTA_THRESHOLD, 16'hFFFF);
		write_reg(REG_WINDOW_LENGTH, 16'd0);
		send_frame(flat_frame(-32768));
		send_frame(flat_frame(32767));
		drain_averages();
		write_reg(REG_DELTA_THRESHOLD, 16'd0);
		send_frame(flat_frame(32767));
		f    = flat_frame(32767);
		f[8] = 16'sd32766;
		send_frame(f);
		drain_averages();
	endtask

	// A second jump inside an open window keeps the sums going
	task automatic test_retrigger_ignored();
		frame_t f;
		write_reg(REG_DELTA_THRESHOLD, 16'd1000);
		write_reg(REG_WINDOW_LENGTH, 16'd3);
		f    = flat_frame(32767);
		f[1] = 16'sh8000;
		send_frame(f);
		send_frame(flat_frame(32767));
		send_frame(flat_frame(-3));
		drain_averages();
	endtask

	// Full-scale values under the longest window, closed early: wide sums and a large divisor
	task automatic test_longest_window();
		frame_t f;
		write_reg(REG_DELTA_THRESHOLD, 16'hFFFF);
		send_frame(flat_frame(0));
		drain_averages();
		write_reg(REG_DELTA_THRESHOLD, 16'd0);
		write_reg(REG_WINDOW_LENGTH, 16'h03FF);
		for (int i = 0; i < NUM_CH; i++) f[i] = (i % 2 == 0) ? 16'h7FFF : 16'h8000;
		repeat (LONG_WINDOW_ITEMS) send_frame(f);
		drain_averages();
		// count has reached the new length, so the next sample closes the window
		write_reg(REG_WINDOW_LENGTH, 16'(LONG_WINDOW_ITEMS));
		send_frame(f);
		drain_averages();
	endtask

	function automatic logic [CFG_W-1:0] pick_threshold();
		case ($urandom_range(0, 9))
			0:       return 16'd0;
			1:       return 16'hFFFF;
			2:       return CFG_W'($urandom);
			default: return CFG_W'($urandom_range(64, 12000));
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_length();
		int r;
		r = $urandom_range(0, 19);
		if (r < 2)  return 16'd0;
		if (r < 12) return CFG_W'($urandom_range(1, 6));
		if (r < 17) return CFG_W'($urandom_range(7, 40));
		if (r == 17) return CFG_W'($urandom_range(100, 150));
		// upper bits are dropped by the 10-bit register
		return {6'($urandom), 10'($urandom_range(1, 12))};
	endfunction

	// Mostly quiet-jump-window sequences, some cut short, some pure noise
	task automatic test_random_traffic();
		int     start_count, phase_end, extra;
		frame_t f;
		start_count = frames_sent;
		while (frames_sent - start_count < RANDOM_ITEMS) begin
			drain_averages();
			write_reg(REG_DELTA_THRESHOLD, pick_threshold());
			write_reg(REG_WINDOW_LENGTH, pick_length());
			sender_idles   = ($urandom_range(0, 3) != 0);
			receiver_idles = ($urandom_range(0, 3) != 0);
			phase_end = frames_sent + $urandom_range(20, 70);
			while (frames_sent < phase_end && frames_sent - start_count < RANDOM_ITEMS) begin
				if ($urandom_range(0, 9) == 0) begin
					for (int i = 0; i < NUM_CH; i++) f[i] = SAMPLE_W'($urandom);
					send_frame(f);
				end else begin
					repeat ($urandom_range(0, 2)) send_frame(quiet_frame());
					send_frame(jump_frame());
					extra = (length_shadow > 1) ? int'(length_shadow) - 1 : 0;
					if ($urandom_range(0, 7) == 0) extra = $urandom_range(0, extra);
					repeat (extra) send_frame(window_frame());
				end
			end
		end
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_registers();
		test_each_lane_triggers();
		test_threshold_extremes();
		test_retrigger_ignored();
		test_longest_window();
		test_random_traffic();
		drain_averages();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Run covered %0d samples, %0d closed windows, %0d averages checked, %0d register writes.",
			frames_sent, windows_closed, averages_seen, cfg_writes);
		$display("Thresholds from 0 to 65535, window lengths from 0 to 1023, random stalls on both sides.");
		if (fail_count == 0 && pending_averages.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("Timeout with %0d averages outstanding", pending_averages.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> motion_triggered_window_averager_top.f
sv/mtwa_pkg.sv
sv/mtwa_front.sv
sv/mtwa_queue.sv
sv/mtwa_back.sv
sv/motion_triggered_window_averager_top.sv
sv/mtwa_checker.sv
sim/tb_motion_triggered_window_averager_top.sv
